@@ rtl/plids_pkg.sv @@
// Shared constants, codes and types for the positional list engine.
`default_nettype none

package plids_pkg;

	// Default list capacity and fixed field widths
	localparam int CAPACITY_DEF = 64;
	localparam int CW = 7;
	localparam int VW = 8;
	localparam int TW = 2;
	localparam int SW = 3;

	// Request codes
	localparam logic [TW-1:0] REQ_INSERT = 2'd0;
	localparam logic [TW-1:0] REQ_DELETE = 2'd1;
	localparam logic [TW-1:0] REQ_SEARCH = 2'd2;
	localparam logic [TW-1:0] REQ_UNUSED = 2'd3;

	// Result status codes
	localparam logic [SW-1:0] ST_DONE     = 3'd0;
	localparam logic [SW-1:0] ST_FULL     = 3'd1;
	localparam logic [SW-1:0] ST_BADPOS   = 3'd2;
	localparam logic [SW-1:0] ST_EMPTY    = 3'd3;
	localparam logic [SW-1:0] ST_FOUND    = 3'd4;
	localparam logic [SW-1:0] ST_NOTFOUND = 3'd5;

	// Result word handed from the sequencer to the output register
	typedef struct packed {
		logic          valid;
		logic [SW-1:0] status;
		logic [CW-1:0] match_position;
		logic [CW-1:0] count;
		logic          last;
	} rsp_load_t;

endpackage

`default_nettype wire

@@ rtl/plids_if.sv @@
// Request and result channel interfaces of the positional list engine.
`default_nettype none

interface plids_req_if;
	logic                     valid;
	logic                     ready;
	logic [plids_pkg::TW-1:0] req_type;
	logic [plids_pkg::CW-1:0] position;
	logic [plids_pkg::VW-1:0] value;

	modport source (output valid, output req_type, output position, output value,
		input ready);
	modport sink (input valid, input req_type, input position, input value,
		output ready);
endinterface

interface plids_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [plids_pkg::SW-1:0] status;
	logic [plids_pkg::CW-1:0] match_position;
	logic [plids_pkg::CW-1:0] count;
	logic                     last;

	modport source (output valid, output status, output match_position, output count,
		output last, input ready);
	modport sink (input valid, input status, input match_position, input count,
		input last, output ready);
endinterface

`default_nettype wire

@@ rtl/plids_store.sv @@
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module plids_store #(
	parameter int CAPACITY = plids_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [plids_pkg::VW-1:0] wdata,
	input  wire logic                     re,
	input  wire logic [AW-1:0]            raddr,
	output logic      [plids_pkg::VW-1:0] rdata
);
	import plids_pkg::*;

	logic [VW-1:0] mem_q [CAPACITY];
	logic [VW-1:0] rdata_q;

	// Write an entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read an entry; hold the word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/plids_seq.sv @@
// Sequencer: checks requests, steps shifts and searches through the entry memory.
`default_nettype none

module plids_seq #(
	parameter int CAPACITY = plids_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	plids_req_if.sink                     req,
	input  wire logic                     load_ok,
	output plids_pkg::rsp_load_t          ld,
	output logic                          mem_we,
	output logic      [AW-1:0]            mem_waddr,
	output logic      [plids_pkg::VW-1:0] mem_wdata,
	output logic                          mem_re,
	output logic      [AW-1:0]            mem_raddr,
	input  wire logic [plids_pkg::VW-1:0] mem_rdata
);
	import plids_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_WR,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic [VW-1:0] val_q;
	logic          have_q;
	logic [CW-1:0] pend_pos_q;
	logic [SW-1:0] res_status_q;
	logic [CW-1:0] res_pos_q;

	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] pos_m1;
	logic [CW-1:0] cap_w;
	logic          ins_more;
	logic          del_more;
	logic          srch_more;
	logic          hit;

	assign cap_w     = CW'(CAPACITY);
	assign idx_m1    = idx_q - CW'(1);
	assign idx_p1    = idx_q + CW'(1);
	assign pos_m1    = pos_q - CW'(1);
	assign ins_more  = (idx_q >= pos_q);
	assign del_more  = (idx_p1 < count_q);
	assign srch_more = (idx_q < count_q);
	assign hit       = (mem_rdata == val_q);

	assign req.ready = (state_q == S_IDLE);

	// Drive the memory ports and the result word from the current step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		ld        = '0;
		case (state_q)
			S_INS_RD: begin
				mem_re    = ins_more;
				mem_raddr = idx_m1[AW-1:0];
			end
			S_INS_WR: begin
				mem_we = 1'b1;
			end
			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_m1[AW-1:0];
				mem_wdata = val_q;
			end
			S_DEL_RD: begin
				mem_re    = del_more;
				mem_raddr = idx_p1[AW-1:0];
			end
			S_DEL_WR: begin
				mem_we = 1'b1;
			end
			S_SRCH_RD: begin
				mem_re = srch_more;
			end
			S_SRCH_CMP: begin
				// a new hit releases the previous one, which is then not the last
				if (hit && have_q) begin
					ld.valid          = 1'b1;
					ld.status         = ST_FOUND;
					ld.match_position = pend_pos_q;
					ld.count          = count_q;
					ld.last           = 1'b0;
				end
			end
			S_EMIT: begin
				ld.valid          = 1'b1;
				ld.status         = res_status_q;
				ld.match_position = res_pos_q;
				ld.count          = count_q;
				ld.last           = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			have_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						pos_q     <= req.position;
						val_q     <= req.value;
						res_pos_q <= '0;
						case (req.req_type)
							REQ_INSERT: begin
								if (count_q >= cap_w) begin
									res_status_q <= ST_FULL;
									state_q      <= S_EMIT;
								end else if (req.position == '0 ||
										req.position > count_q + CW'(1)) begin
									res_status_q <= ST_BADPOS;
									state_q      <= S_EMIT;
								end else begin
									idx_q   <= count_q;
									state_q <= S_INS_RD;
								end
							end
							REQ_DELETE: begin
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_EMIT;
								end else if (req.position == '0 ||
										req.position > count_q) begin
									res_status_q <= ST_BADPOS;
									state_q      <= S_EMIT;
								end else begin
									idx_q   <= req.position - CW'(1);
									state_q <= S_DEL_RD;
								end
							end
							REQ_SEARCH: begin
								idx_q   <= '0;
								have_q  <= 1'b0;
								state_q <= S_SRCH_RD;
							end
							default: begin
								// unused request: drop it
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= ins_more ? S_INS_WR : S_INS_PUT;
				end
				S_INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_INS_RD;
				end
				S_INS_PUT: begin
					count_q      <= count_q + CW'(1);
					res_status_q <= ST_DONE;
					state_q      <= S_EMIT;
				end
				S_DEL_RD: begin
					if (del_more) begin
						state_q <= S_DEL_WR;
					end else begin
						count_q      <= count_q - CW'(1);
						res_status_q <= ST_DONE;
						state_q      <= S_EMIT;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_p1;
					state_q <= S_DEL_RD;
				end
				S_SRCH_RD: begin
					if (srch_more) begin
						state_q <= S_SRCH_CMP;
					end else if (have_q) begin
						res_status_q <= ST_FOUND;
						res_pos_q    <= pend_pos_q;
						state_q      <= S_EMIT;
					end else begin
						res_status_q <= ST_NOTFOUND;
						state_q      <= S_EMIT;
					end
				end
				S_SRCH_CMP: begin
					// hold while an earlier hit waits for the output register
					if (!(hit && have_q && !load_ok)) begin
						if (hit) begin
							pend_pos_q <= idx_p1;
							have_q     <= 1'b1;
						end
						idx_q   <= idx_p1;
						state_q <= S_SRCH_RD;
					end
				end
				S_EMIT: begin
					if (load_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/positional_list_insert_delete_search_unit.sv @@
// Top level of the positional list engine: sequencer, entry memory, result register.
//
//   channel | dir | words                       | payload
//   req     | in  | one per request             | req_type, position, value
//   rsp     | out | 1 per insert/delete, 1..N   | status, match_position, count, last
//           |     | per search                  |
//
// While busy, each step of a request is one memory read and one write or compare on
// the single port pair of the entry memory; output stalls add to the busy time.
// Failed requests go straight to their result word without a memory access.
// Reset clears the count and the sequencer; the entries are not cleared.
// The result register lets the next request in while the last word waits; a stalled
// output holds the sequencer only when a further word must be issued.
`default_nettype none

module positional_list_insert_delete_search_unit #(
	parameter int CAPACITY = plids_pkg::CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	plids_req_if.sink req,
	plids_rsp_if.source rsp
);
	import plids_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	rsp_load_t     ld;
	logic          load_ok;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [VW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [VW-1:0] mem_rdata;

	logic          out_valid_q;
	logic [SW-1:0] out_status_q;
	logic [CW-1:0] out_pos_q;
	logic [CW-1:0] out_count_q;
	logic          out_last_q;

	plids_seq #(.CAPACITY(CAPACITY), .AW(AW)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.load_ok   (load_ok),
		.ld        (ld),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	plids_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign load_ok = !out_valid_q || rsp.ready;

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld.valid && load_ok) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (ld.valid && load_ok) begin
			out_status_q <= ld.status;
			out_pos_q    <= ld.match_position;
			out_count_q  <= ld.count;
			out_last_q   <= ld.last;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.match_position = out_pos_q;
	assign rsp.count          = out_count_q;
	assign rsp.last           = out_last_q;

endmodule

`default_nettype wire

@@ rtl/plids_checker.sv @@
// Port-level checks for the positional list engine, bound to the top level.
`default_nettype none

module plids_checker #(
	parameter int CAPACITY = plids_pkg::CAPACITY_DEF
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     req_valid,
	input wire logic                     req_ready,
	input wire logic [plids_pkg::TW-1:0] req_type,
	input wire logic                     rsp_valid,
	input wire logic                     rsp_ready,
	input wire logic [plids_pkg::SW-1:0] status,
	input wire logic [plids_pkg::CW-1:0] match_position,
	input wire logic [plids_pkg::CW-1:0] count,
	input wire logic                     last
);
	import plids_pkg::*;

	// A stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
			$stable(match_position) && $stable(count) && $stable(last))
		else $error("result word changed while stalled");

	// A taken request of a used type clears request ready in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type != REQ_UNUSED |=> !req_ready)
		else $error("request port ready right after a real request");

	// Match position is set exactly on found results and lies within the list; other results are last
	a_match_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((status == ST_FOUND) ? (match_position != '0 &&
			match_position <= count) : (match_position == '0 && last)))
		else $error("match position or last flag inconsistent with status");

	// Count never exceeds the capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= CW'(CAPACITY))
		else $error("count beyond capacity");

endmodule

bind positional_list_insert_delete_search_unit plids_checker #(.CAPACITY(CAPACITY)) u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_type       (req.req_type),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.match_position (rsp.match_position),
	.count          (rsp.count),
	.last           (rsp.last)
);

`default_nettype wire
